>>> design/dpce_pkg.sv
package dpce_pkg;

  // default depth of the job queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // reset values of the configuration registers
  localparam logic [15:0] EndColumnRst = 16'd320;
  localparam logic [15:0] EndRowRst    = 16'd240;

  // controller command bytes
  localparam logic [7:0] CmdColumn   = 8'h2A;
  localparam logic [7:0] CmdRow      = 8'h2B;
  localparam logic [7:0] CmdMemWrite = 8'h2C;

  // operation codes
  localparam logic [1:0] OpSetWindow  = 2'd0;
  localparam logic [1:0] OpPutPoint   = 2'd1;
  localparam logic [1:0] OpWritePixel = 2'd2;

  // configuration register index, taken from paddr[2]
  localparam logic RegEndColumn = 1'b0;
  localparam logic RegEndRow    = 1'b1;

  // byte slots of one job, sent in ascending order
  localparam int unsigned NumSlots = 13;
  localparam logic [3:0] SlotColCmd  = 4'd0;
  localparam logic [3:0] SlotColAHi  = 4'd1;
  localparam logic [3:0] SlotColALo  = 4'd2;
  localparam logic [3:0] SlotColBHi  = 4'd3;
  localparam logic [3:0] SlotColBLo  = 4'd4;
  localparam logic [3:0] SlotRowCmd  = 4'd5;
  localparam logic [3:0] SlotRowAHi  = 4'd6;
  localparam logic [3:0] SlotRowALo  = 4'd7;
  localparam logic [3:0] SlotRowBHi  = 4'd8;
  localparam logic [3:0] SlotRowBLo  = 4'd9;
  localparam logic [3:0] SlotMemWr   = 4'd10;
  localparam logic [3:0] SlotColorHi = 4'd11;
  localparam logic [3:0] SlotColorLo = 4'd12;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] end_column;
    logic [15:0] end_row;
  } cfg_t;

  // one classified request: which slots to send and their words
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [15:0]         col_a;
    logic [15:0]         col_b;
    logic [15:0]         row_a;
    logic [15:0]         row_b;
    logic [15:0]         color;
  } job_t;

endpackage

>>> design/dpce_front.sv
module dpce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dpce_pkg::in_item_t in_data_i,
  input  dpce_pkg::cfg_t     cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output dpce_pkg::job_t     job_o
);
  import dpce_pkg::*;

  logic        known_q, known_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        accept;
  logic        col_cmd, row_cmd;

  assign accept = in_valid_i && !full_i;

  // address commands that auto-increment does not cover
  assign col_cmd = !known_q ||
                   ((in_data_i.x_start != col_q) &&
                    ({1'b0, in_data_i.x_start} != ({1'b0, col_q} + 17'd1)));
  assign row_cmd = !known_q || (in_data_i.y_start != row_q);

  // classify request into a slot mask
  always_comb begin
    job_o       = '0;
    job_o.col_a = in_data_i.x_start;
    job_o.row_a = in_data_i.y_start;
    job_o.color = in_data_i.color;
    job_o.col_b = cfg_i.end_column;
    job_o.row_b = cfg_i.end_row;
    push_o      = 1'b0;
    known_d     = known_q;
    col_d       = col_q;
    row_d       = row_q;
    case (in_data_i.op)
      OpSetWindow: begin
        job_o.col_b = in_data_i.x_end;
        job_o.row_b = in_data_i.y_end;
        for (int i = 0; i <= int'(SlotMemWr); i++) job_o.mask[i] = 1'b1;
        push_o  = accept;
        if (accept) known_d = 1'b0;
      end
      OpPutPoint: begin
        if (col_cmd) begin
          job_o.mask[SlotColCmd] = 1'b1;
          job_o.mask[SlotColAHi] = 1'b1;
          job_o.mask[SlotColALo] = 1'b1;
          job_o.mask[SlotColBHi] = !known_q;
          job_o.mask[SlotColBLo] = !known_q;
        end
        if (row_cmd) begin
          job_o.mask[SlotRowCmd] = 1'b1;
          job_o.mask[SlotRowAHi] = 1'b1;
          job_o.mask[SlotRowALo] = 1'b1;
          job_o.mask[SlotRowBHi] = !known_q;
          job_o.mask[SlotRowBLo] = !known_q;
        end
        job_o.mask[SlotMemWr]   = col_cmd || row_cmd;
        job_o.mask[SlotColorHi] = 1'b1;
        job_o.mask[SlotColorLo] = 1'b1;
        push_o = accept;
        if (accept) begin
          known_d = 1'b1;
          col_d   = in_data_i.x_start;
          row_d   = in_data_i.y_start;
        end
      end
      OpWritePixel: begin
        job_o.mask[SlotColorHi] = 1'b1;
        job_o.mask[SlotColorLo] = 1'b1;
        push_o = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // cached position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      known_q <= known_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

>>> design/dpce_queue.sv
module dpce_queue #(
  parameter int unsigned Depth = dpce_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dpce_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output dpce_pkg::job_t pop_job_o
);
  import dpce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

>>> design/dpce_back.sv
module dpce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  dpce_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpce_pkg::out_item_t out_data_o
);
  import dpce_pkg::*;

  job_t                job_q;
  logic [NumSlots-1:0] mask_q;
  logic [NumSlots-1:0] sel_onehot, rest;
  logic [3:0]          slot;
  logic                out_valid_q;
  out_item_t           out_q;
  out_item_t           cur;
  logic                advance, emit, load;

  // lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) slot = 4'(i);
    end
  end
  assign sel_onehot = mask_q & (~mask_q + NumSlots'(1));
  assign rest       = mask_q & ~sel_onehot;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && (mask_q != '0);
  assign load    = job_valid_i && ((mask_q == '0) || (emit && (rest == '0)));
  assign pop_o   = load;

  // byte for the selected slot
  always_comb begin
    cur.is_data = 1'b1;
    cur.last    = (rest == '0);
    case (slot)
      SlotColCmd:  begin cur.byte_out = CmdColumn;   cur.is_data = 1'b0; end
      SlotColAHi:  cur.byte_out = job_q.col_a[15:8];
      SlotColALo:  cur.byte_out = job_q.col_a[7:0];
      SlotColBHi:  cur.byte_out = job_q.col_b[15:8];
      SlotColBLo:  cur.byte_out = job_q.col_b[7:0];
      SlotRowCmd:  begin cur.byte_out = CmdRow;      cur.is_data = 1'b0; end
      SlotRowAHi:  cur.byte_out = job_q.row_a[15:8];
      SlotRowALo:  cur.byte_out = job_q.row_a[7:0];
      SlotRowBHi:  cur.byte_out = job_q.row_b[15:8];
      SlotRowBLo:  cur.byte_out = job_q.row_b[7:0];
      SlotMemWr:   begin cur.byte_out = CmdMemWrite; cur.is_data = 1'b0; end
      SlotColorHi: cur.byte_out = job_q.color[15:8];
      SlotColorLo: cur.byte_out = job_q.color[7:0];
      default:     cur.byte_out = '0;
    endcase
  end

  // slot mask and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) mask_q <= job_i.mask;
      else if (emit) mask_q <= rest;
      if (advance) out_valid_q <= (mask_q != '0);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    if (emit) out_q <= cur;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/display_pixel_command_encoder.sv
// Display pixel command encoder: turns set window, put point and write pixel
// requests into controller bytes, one output transfer per byte with a
// command/data flag and a last flag on the final byte of each request.
// The back sequencer sends one byte per cycle while the output is not
// stalled. A request has 2 bytes for write pixel or a put point that needs
// no address command, up to 13 for a put point while the position is
// unknown, and 11 for set window. A request is taken every cycle while the
// job queue (QueueDepth entries) has room. Op code 3 is dropped. end_column
// (address 0) and end_row (address 4) are to be written by the user over the
// APB port only while idle; the block itself does not enforce this.
module display_pixel_command_encoder #(
  parameter int unsigned QueueDepth = dpce_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dpce_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpce_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dpce_pkg::*;

  cfg_t cfg_q;
  logic full, push, pop, job_valid;
  job_t push_job, pop_job;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_column <= EndColumnRst;
      cfg_q.end_row    <= EndRowRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegEndColumn: cfg_q.end_column <= pwdata[15:0];
        RegEndRow:    cfg_q.end_row    <= pwdata[15:0];
        default:      cfg_q.end_column <= cfg_q.end_column;
      endcase
    end
  end

  // read back
  assign prdata = {16'd0, (paddr[2] == RegEndRow) ? cfg_q.end_row : cfg_q.end_column};

  assign in_stall_o = full;

  dpce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  dpce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (job_valid),
    .pop_job_o   (pop_job)
  );

  dpce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/dpce_checker.sv
module dpce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input dpce_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dpce_pkg::out_item_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);
  import dpce_pkg::*;

  // stalled input transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // command bytes are only the three controller commands
  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_data |->
      (out_data_o.byte_out == CmdColumn) || (out_data_o.byte_out == CmdRow) ||
      (out_data_o.byte_out == CmdMemWrite))
    else $error("bad command byte");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("busy after reset");

  // a register write reads back at once
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready) && $past(rst_ni) &&
    ($past(paddr[2]) == paddr[2]) |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("register read back mismatch");

endmodule

bind display_pixel_command_encoder dpce_checker u_dpce_checker (.*);
